[rtl/footprint_collision_escape_macros.svh]
// Assertion helpers for the footprint collision escape block.
// Each macro takes a label, the clock, the active-low reset, a condition and
// the property that must follow from it.
`ifndef FOOTPRINT_COLLISION_ESCAPE_MACROS_SVH
`define FOOTPRINT_COLLISION_ESCAPE_MACROS_SVH
`ifndef SYNTHESIS
// Check the property in the same cycle as the condition.
`define FCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("footprint collision escape: assertion failed");
// Check the property in the cycle after the condition.
`define FCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("footprint collision escape: assertion failed");
`else
`define FCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define FCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/fce_pkg.sv]
package fce_pkg;

  // Grid and footprint limits
  localparam int GRID_DIM_MAX = 1024;
  localparam int RADIUS_MAX   = 63;
  localparam int COORD_W      = $clog2(GRID_DIM_MAX);
  localparam int DIM_W        = COORD_W + 1;

  // Fixed field widths
  localparam int RADIUS_W = 6;
  localparam int COST_W   = 8;
  localparam int SPEED_W  = 12;
  localparam int TICKS_W  = 16;
  localparam int SUM_W    = 22;
  localparam int DIR_W    = 16;
  localparam int VEL_W    = 13;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic [DIM_W-1:0]          GRID_WIDTH_RST  = DIM_W'(64);
  localparam logic [DIM_W-1:0]          GRID_HEIGHT_RST = DIM_W'(64);
  localparam logic [COORD_W-1:0]        ROBOT_COL_RST   = COORD_W'(32);
  localparam logic [COORD_W-1:0]        ROBOT_ROW_RST   = COORD_W'(32);
  localparam logic [RADIUS_W-1:0]       RADIUS_RST      = RADIUS_W'(4);
  localparam logic signed [COST_W-1:0]  COST_THR_RST    = COST_W'(80);
  localparam logic [SPEED_W-1:0]        SPEED_RST       = SPEED_W'(200);
  localparam logic [TICKS_W-1:0]        TICKS_RST       = TICKS_W'(1000);

  // Fallback direction when the away vector cancels out: straight back
  localparam logic [DIR_W-1:0] DIR_BACK_MAG = DIR_W'(32768);

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  // Input word kinds
  localparam logic MODE_CELL = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH     = 3'd0,
    CFG_GRID_HEIGHT    = 3'd1,
    CFG_ROBOT_COL      = 3'd2,
    CFG_ROBOT_ROW      = 3'd3,
    CFG_RADIUS_CELLS   = 3'd4,
    CFG_COST_THRESHOLD = 3'd5,
    CFG_ESCAPE_SPEED   = 3'd6,
    CFG_ESCAPE_TICKS   = 3'd7
  } cfg_idx_e;

  // Request to the direction and velocity unit
  typedef struct packed {
    logic                      start;
    logic                      ack;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [DIR_W-1:0]   last_x;
    logic signed [DIR_W-1:0]   last_y;
    logic        [SPEED_W-1:0] speed;
  } norm_req_t;

  // Response from the direction and velocity unit
  typedef struct packed {
    logic                    done;
    logic                    dir_upd;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [VEL_W-1:0] vel_fwd;
    logic signed [VEL_W-1:0] vel_left;
  } norm_rsp_t;

endpackage

[rtl/fce_norm.sv]
// Direction and velocity unit: scales the away vector, takes the root of
// its squared length bit by bit, divides each component by it one quotient
// bit a cycle, and scales the unit direction by the speed. One multiplier
// serves the squares and speed products, one subtractor the root and divides.
module fce_norm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fce_pkg::norm_req_t req_i,
  output fce_pkg::norm_rsp_t rsp_o
);

  typedef enum logic [11:0] {
    N_IDLE   = 12'b0000_0000_0001,
    N_SHIFT  = 12'b0000_0000_0010,
    N_SQX    = 12'b0000_0000_0100,
    N_SQY    = 12'b0000_0000_1000,
    N_SQSUM  = 12'b0000_0001_0000,
    N_SQRT   = 12'b0000_0010_0000,
    N_DIVSET = 12'b0000_0100_0000,
    N_DIV    = 12'b0000_1000_0000,
    N_VELX   = 12'b0001_0000_0000,
    N_VELY   = 12'b0010_0000_0000,
    N_ROUND  = 12'b0100_0000_0000,
    N_DONE   = 12'b1000_0000_0000
  } norm_state_e;

  localparam int SW = fce_pkg::SUM_W;
  localparam int DW = fce_pkg::DIR_W;
  localparam int VW = fce_pkg::VEL_W;

  norm_state_e state_q, state_d;

  logic [SW-1:0] ax_q, ax_d, ay_q, ay_d;
  logic          negx_q, negx_d, negy_q, negy_d;
  logic          upd_q, upd_d;
  logic          sel_q, sel_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [31:0]   s_q, s_d;
  logic [63:0]   rad_q, rad_d;
  logic [48:0]   acc_q, acc_d;
  logic [48:0]   dvs_q, dvs_d;
  logic [31:0]   root_q, root_d;
  logic [16:0]   quot_q, quot_d;
  logic [DW-1:0] magx_q, magx_d, magy_q, magy_d;
  logic [VW-1:0] px_q, px_d, py_q, py_d;

  // Shared multiplier, registered output
  logic [15:0] mul_a, mul_b;
  logic [31:0] prod_q;

  // Shared subtract/compare unit
  logic [48:0] sub_a, sub_b, sub_diff;
  logic        sub_borrow, sub_ge;

  logic [SW-1:0] ax_start, ay_start;
  logic [SW-1:0] both_mag;
  logic [32:0]   sq_sum;
  logic [15:0]   div_comp;
  logic [46:0]   div_num;
  logic [16:0]   q_fin;
  logic [DW-1:0] q_sat;
  logic [32:0]   rnd;

  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_borrow;

  assign ax_start = req_i.sum_x[SW-1] ? SW'(-req_i.sum_x) : SW'(req_i.sum_x);
  assign ay_start = req_i.sum_y[SW-1] ? SW'(-req_i.sum_y) : SW'(req_i.sum_y);
  assign both_mag = ax_q | ay_q;
  assign sq_sum   = {1'b0, s_q} + {1'b0, prod_q};
  assign div_comp = sel_q ? ay_q[15:0] : ax_q[15:0];
  assign div_num  = {1'b0, div_comp, 30'b0} + {16'b0, root_q[31:1]};
  assign q_fin    = {quot_q[15:0], sub_ge};
  assign q_sat    = (q_fin > 17'd32767) ? DW'(32767) : q_fin[15:0];
  assign rnd      = {1'b0, prod_q} + 33'd16384;

  // Sequence the shared units
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    negx_d  = negx_q;
    negy_d  = negy_q;
    upd_d   = upd_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    s_d     = s_q;
    rad_d   = rad_q;
    acc_d   = acc_q;
    dvs_d   = dvs_q;
    root_d  = root_q;
    quot_d  = quot_q;
    magx_d  = magx_q;
    magy_d  = magy_q;
    px_d    = px_q;
    py_d    = py_q;
    mul_a   = ax_q[15:0];
    mul_b   = ax_q[15:0];
    sub_a   = acc_q;
    sub_b   = dvs_q;
    case (state_q)
      N_IDLE: begin
        if (req_i.start) begin
          ax_d   = ax_start;
          ay_d   = ay_start;
          negx_d = req_i.sum_x[SW-1];
          negy_d = req_i.sum_y[SW-1];
          upd_d  = 1'b1;
          state_d = N_SHIFT;
          if (req_i.sum_x == '0 && req_i.sum_y == '0) begin
            // Away vector cancels: reuse the last direction or back off
            upd_d = 1'b0;
            state_d = N_VELX;
            if (req_i.last_x != '0 || req_i.last_y != '0) begin
              negx_d = req_i.last_x[DW-1];
              negy_d = req_i.last_y[DW-1];
              magx_d = req_i.last_x[DW-1] ? DW'(-req_i.last_x) : DW'(req_i.last_x);
              magy_d = req_i.last_y[DW-1] ? DW'(-req_i.last_y) : DW'(req_i.last_y);
            end else begin
              negx_d = 1'b0;
              negy_d = 1'b1;
              magx_d = '0;
              magy_d = fce_pkg::DIR_BACK_MAG;
            end
          end
        end
      end
      N_SHIFT: begin
        // Bring the larger magnitude into [2^15, 2^16)
        if (both_mag[SW-1:15] == '0) begin
          ax_d = {ax_q[SW-2:0], 1'b0};
          ay_d = {ay_q[SW-2:0], 1'b0};
        end else if (both_mag[SW-1:16] != '0) begin
          ax_d = {1'b0, ax_q[SW-1:1]};
          ay_d = {1'b0, ay_q[SW-1:1]};
        end else begin
          state_d = N_SQX;
        end
      end
      N_SQX: begin
        state_d = N_SQY;
      end
      N_SQY: begin
        mul_a = ay_q[15:0];
        mul_b = ay_q[15:0];
        s_d   = prod_q;
        state_d = N_SQSUM;
      end
      N_SQSUM: begin
        rad_d  = {1'b0, sq_sum, 30'b0};
        acc_d  = '0;
        root_d = '0;
        cnt_d  = 5'd31;
        state_d = N_SQRT;
      end
      N_SQRT: begin
        // One root bit per cycle from the top two radicand bits
        sub_a  = {14'b0, acc_q[32:0], rad_q[63:62]};
        sub_b  = {15'b0, root_q, 2'b01};
        acc_d  = sub_ge ? sub_diff : sub_a;
        root_d = {root_q[30:0], sub_ge};
        rad_d  = {rad_q[61:0], 2'b00};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          sel_d   = 1'b0;
          state_d = N_DIVSET;
        end
      end
      N_DIVSET: begin
        // Rounded quotient: add half the divisor to the numerator
        acc_d  = {2'b0, div_num};
        dvs_d  = {1'b0, root_q, 16'b0};
        quot_d = '0;
        cnt_d  = 5'd16;
        state_d = N_DIV;
      end
      N_DIV: begin
        sub_a  = acc_q;
        sub_b  = dvs_q;
        acc_d  = sub_ge ? sub_diff : acc_q;
        quot_d = q_fin;
        dvs_d  = {1'b0, dvs_q[48:1]};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          if (!sel_q) begin
            magx_d  = q_sat;
            sel_d   = 1'b1;
            state_d = N_DIVSET;
          end else begin
            magy_d  = q_sat;
            state_d = N_VELX;
          end
        end
      end
      N_VELX: begin
        mul_a = magx_q;
        mul_b = {4'b0, req_i.speed};
        state_d = N_VELY;
      end
      N_VELY: begin
        mul_a = magy_q;
        mul_b = {4'b0, req_i.speed};
        px_d  = rnd[27:15];
        state_d = N_ROUND;
      end
      N_ROUND: begin
        py_d  = rnd[27:15];
        state_d = N_DONE;
      end
      N_DONE: begin
        if (req_i.ack) begin
          state_d = N_IDLE;
        end
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      upd_q   <= upd_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    negx_q <= negx_d;
    negy_q <= negy_d;
    s_q    <= s_d;
    rad_q  <= rad_d;
    acc_q  <= acc_d;
    dvs_q  <= dvs_d;
    root_q <= root_d;
    quot_q <= quot_d;
    magx_q <= magx_d;
    magy_q <= magy_d;
    px_q   <= px_d;
    py_q   <= py_d;
    prod_q <= mul_a * mul_b;
  end

  // Apply signs: forward follows y, left is minus x
  assign rsp_o.done     = (state_q == N_DONE);
  assign rsp_o.dir_upd  = upd_q;
  assign rsp_o.dir_x    = negx_q ? DW'(16'd0 - magx_q) : magx_q;
  assign rsp_o.dir_y    = negy_q ? DW'(16'd0 - magy_q) : magy_q;
  assign rsp_o.vel_fwd  = negy_q ? VW'(13'd0 - py_q) : py_q;
  assign rsp_o.vel_left = negx_q ? px_q : VW'(13'd0 - px_q);

endmodule

[rtl/footprint_collision_escape.sv]
// Footprint collision check with escape command generation.
// Cells and ticks are taken one per cycle unless the input stalls, as it does while the
// direction unit works; a stop word is ready the cycle after its tick. A frame's last
// cell with an obstacle occupies the direction unit through the scaling shifts, root,
// two divides, speed products and handoff; a cancelled away vector skips to the products.
// Reset (rst_ni low, asynchronous) restores register defaults and clears all control state.
`include "footprint_collision_escape_macros.svh"
module footprint_collision_escape (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fce_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fce_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic signed [fce_pkg::COST_W-1:0]   cell_cost_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                command_kind_o,
  output logic signed [fce_pkg::VEL_W-1:0]    vel_forward_o,
  output logic signed [fce_pkg::VEL_W-1:0]    vel_left_o
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_NORM = 2'b10
  } top_state_e;

  localparam int CW = fce_pkg::COORD_W;
  localparam int DMW = fce_pkg::DIM_W;
  localparam int SW = fce_pkg::SUM_W;
  localparam int RW = fce_pkg::RADIUS_W;

  // Configuration registers
  logic [DMW-1:0]                       grid_width_q, grid_height_q;
  logic [CW-1:0]                        robot_col_q, robot_row_q;
  logic [RW-1:0]                        radius_q;
  logic signed [fce_pkg::COST_W-1:0]    cost_thr_q;
  logic [fce_pkg::SPEED_W-1:0]          speed_q;
  logic [fce_pkg::TICKS_W-1:0]          esc_ticks_q;

  // Control state
  top_state_e                        state_q, state_d;
  logic [CW-1:0]                     col_q, col_d, row_q, row_d;
  logic signed [SW-1:0]              sumx_q, sumx_d, sumy_q, sumy_d;
  logic                              hit_q, hit_d, escaping_q, escaping_d, skip_q, skip_d;
  logic [fce_pkg::TICKS_W-1:0]       ticks_q, ticks_d;
  logic signed [fce_pkg::DIR_W-1:0]  lastx_q, lastx_d, lasty_q, lasty_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic                              kind_q, kind_d;
  logic signed [fce_pkg::VEL_W-1:0]  fwd_q, fwd_d, left_q, left_d;

  fce_pkg::norm_req_t norm_req;
  fce_pkg::norm_rsp_t norm_rsp;

  logic in_accept, out_free, stop_now;
  logic first_cell, skip_cur, obstacle, inside_box, inside_disc;
  logic [RW-1:0]        r_eff;
  logic signed [DMW-1:0] ox, oy, r_s;
  logic [DMW-1:0]       oxm, oym;
  logic [11:0]          ox_sq, oy_sq, r_sq;
  logic [12:0]          dist_sq;
  logic [DMW-1:0]       w_eff, h_eff, w_m1, h_m1;
  logic                 row_end, frame_end;
  logic signed [SW-1:0] sumx_base, sumy_base;
  logic                 hit_base;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign stop_now  = (mode_i == fce_pkg::MODE_TICK) && escaping_q && (ticks_q <= 16'd1);
  assign in_stall_o = (state_q != T_IDLE) || (stop_now && !out_free);
  assign in_accept = in_valid_i && !in_stall_o;

  // Clamp grid size and radius
  always_comb begin
    w_eff = grid_width_q;
    if (grid_width_q == '0) w_eff = DMW'(1);
    else if (grid_width_q > DMW'(fce_pkg::GRID_DIM_MAX)) w_eff = DMW'(fce_pkg::GRID_DIM_MAX);
    h_eff = grid_height_q;
    if (grid_height_q == '0) h_eff = DMW'(1);
    else if (grid_height_q > DMW'(fce_pkg::GRID_DIM_MAX)) h_eff = DMW'(fce_pkg::GRID_DIM_MAX);
  end
  assign w_m1  = w_eff - DMW'(1);
  assign h_m1  = h_eff - DMW'(1);
  assign r_eff = ({1'b0, radius_q} > (RW + 1)'(fce_pkg::RADIUS_MAX))
                 ? RW'(fce_pkg::RADIUS_MAX) : radius_q;

  // Footprint test for the current raster position
  assign ox  = signed'({1'b0, robot_col_q}) - signed'({1'b0, col_q});
  assign oy  = signed'({1'b0, robot_row_q}) - signed'({1'b0, row_q});
  assign r_s = signed'(DMW'(r_eff));
  assign oxm = ox[DMW-1] ? DMW'(-ox) : DMW'(ox);
  assign oym = oy[DMW-1] ? DMW'(-oy) : DMW'(oy);
  assign inside_box = (ox >= -r_s) && (ox <= r_s) && (oy >= -r_s) && (oy <= r_s);
  assign ox_sq   = oxm[RW-1:0] * oxm[RW-1:0];
  assign oy_sq   = oym[RW-1:0] * oym[RW-1:0];
  assign r_sq    = r_eff * r_eff;
  assign dist_sq = {1'b0, ox_sq} + {1'b0, oy_sq};
  assign inside_disc = inside_box && (dist_sq <= {1'b0, r_sq});

  assign first_cell = (col_q == '0) && (row_q == '0);
  assign skip_cur   = first_cell ? escaping_q : skip_q;
  assign sumx_base  = first_cell ? '0 : sumx_q;
  assign sumy_base  = first_cell ? '0 : sumy_q;
  assign hit_base   = first_cell ? 1'b0 : hit_q;
  assign obstacle   = !skip_cur && inside_disc && (cell_cost_i >= cost_thr_q);
  assign row_end    = ({1'b0, col_q} >= w_m1);
  assign frame_end  = row_end && ({1'b0, row_q} >= h_m1);

  // Advance raster, sums, escape timer and output word
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    sumx_d      = sumx_q;
    sumy_d      = sumy_q;
    hit_d       = hit_q;
    skip_d      = skip_q;
    escaping_d  = escaping_q;
    ticks_d     = ticks_q;
    lastx_d     = lastx_q;
    lasty_d     = lasty_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    fwd_d       = fwd_q;
    left_d      = left_q;
    norm_req.start  = 1'b0;
    norm_req.ack    = 1'b0;
    norm_req.sum_x  = '0;
    norm_req.sum_y  = '0;
    norm_req.last_x = lastx_q;
    norm_req.last_y = lasty_q;
    norm_req.speed  = speed_q;
    case (state_q)
      T_IDLE: begin
        if (in_accept && mode_i == fce_pkg::MODE_TICK) begin
          if (escaping_q) begin
            if (stop_now) begin
              ticks_d     = '0;
              escaping_d  = 1'b0;
              out_valid_d = 1'b1;
              kind_d      = fce_pkg::CMD_STOP;
              fwd_d       = '0;
              left_d      = '0;
            end else begin
              ticks_d = ticks_q - 16'd1;
            end
          end
        end else if (in_accept) begin
          sumx_d = obstacle ? sumx_base + SW'(ox) : sumx_base;
          sumy_d = obstacle ? sumy_base + SW'(oy) : sumy_base;
          hit_d  = hit_base || obstacle;
          skip_d = skip_cur;
          if (frame_end) begin
            col_d = '0;
            row_d = '0;
            if (!skip_cur && hit_d) begin
              norm_req.start = 1'b1;
              norm_req.sum_x = sumx_d;
              norm_req.sum_y = sumy_d;
              state_d = T_NORM;
            end
          end else if (row_end) begin
            col_d = '0;
            row_d = row_q + CW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      T_NORM: begin
        // Issue the start word once the direction unit is done and the output register is free
        if (norm_rsp.done && out_free) begin
          norm_req.ack = 1'b1;
          out_valid_d  = 1'b1;
          kind_d       = fce_pkg::CMD_START;
          fwd_d        = norm_rsp.vel_fwd;
          left_d       = norm_rsp.vel_left;
          escaping_d   = 1'b1;
          ticks_d      = esc_ticks_q;
          if (norm_rsp.dir_upd) begin
            lastx_d = norm_rsp.dir_x;
            lasty_d = norm_rsp.dir_y;
          end
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= fce_pkg::GRID_WIDTH_RST;
      grid_height_q <= fce_pkg::GRID_HEIGHT_RST;
      robot_col_q   <= fce_pkg::ROBOT_COL_RST;
      robot_row_q   <= fce_pkg::ROBOT_ROW_RST;
      radius_q      <= fce_pkg::RADIUS_RST;
      cost_thr_q    <= fce_pkg::COST_THR_RST;
      speed_q       <= fce_pkg::SPEED_RST;
      esc_ticks_q   <= fce_pkg::TICKS_RST;
    end else if (cfg_we_i) begin
      case (fce_pkg::cfg_idx_e'(cfg_index_i))
        fce_pkg::CFG_GRID_WIDTH:     grid_width_q  <= cfg_data_i[DMW-1:0];
        fce_pkg::CFG_GRID_HEIGHT:    grid_height_q <= cfg_data_i[DMW-1:0];
        fce_pkg::CFG_ROBOT_COL:      robot_col_q   <= cfg_data_i[CW-1:0];
        fce_pkg::CFG_ROBOT_ROW:      robot_row_q   <= cfg_data_i[CW-1:0];
        fce_pkg::CFG_RADIUS_CELLS:   radius_q      <= cfg_data_i[RW-1:0];
        fce_pkg::CFG_COST_THRESHOLD: cost_thr_q    <= signed'(cfg_data_i[fce_pkg::COST_W-1:0]);
        fce_pkg::CFG_ESCAPE_SPEED:   speed_q       <= cfg_data_i[fce_pkg::SPEED_W-1:0];
        fce_pkg::CFG_ESCAPE_TICKS:   esc_ticks_q   <= cfg_data_i[fce_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      sumx_q      <= '0;
      sumy_q      <= '0;
      hit_q       <= 1'b0;
      skip_q      <= 1'b0;
      escaping_q  <= 1'b0;
      ticks_q     <= '0;
      lastx_q     <= '0;
      lasty_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      sumx_q      <= sumx_d;
      sumy_q      <= sumy_d;
      hit_q       <= hit_d;
      skip_q      <= skip_d;
      escaping_q  <= escaping_d;
      ticks_q     <= ticks_d;
      lastx_q     <= lastx_d;
      lasty_q     <= lasty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold output word
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    fwd_q  <= fwd_d;
    left_q <= left_d;
  end

  fce_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (norm_req),
    .rsp_o  (norm_rsp)
  );

  assign out_valid_o    = out_valid_q;
  assign command_kind_o = kind_q;
  assign vel_forward_o  = fwd_q;
  assign vel_left_o     = left_q;

  `FCE_ASSERT_NOW(a_norm_stalls_input, clk_i, rst_ni, state_q == T_NORM, in_stall_o)
  `FCE_ASSERT_NOW(a_timer_clear_when_idle, clk_i, rst_ni, !escaping_q, ticks_q == '0)
  `FCE_ASSERT_NEXT(a_last_tick_stops, clk_i, rst_ni, in_accept && stop_now, out_valid_o && (command_kind_o == fce_pkg::CMD_STOP))

endmodule

[dv/footprint_collision_escape_tb.sv]
`timescale 1ns / 100ps

module footprint_collision_escape_tb;
  import fce_pkg::*;

  // One escape command as it leaves the block
  typedef struct {
    logic                    kind;
    logic signed [VEL_W-1:0] fwd_v;
    logic signed [VEL_W-1:0] left_v;
  } escape_cmd_t;

  // Footprint scan and escape sequencing, mirrored at word level
  class escape_cmd_model;
    logic [DIM_W-1:0]          grid_w;
    logic [DIM_W-1:0]          grid_h;
    logic [COORD_W-1:0]        bot_col;
    logic [COORD_W-1:0]        bot_row;
    logic [RADIUS_W-1:0]       radius;
    logic signed [COST_W-1:0]  cost_thr;
    logic [SPEED_W-1:0]        speed;
    logic [TICKS_W-1:0]        ticks_cfg;

    int unsigned col_pos;
    int unsigned row_pos;
    longint      sum_x;
    longint      sum_y;
    bit          hit;
    bit          escaping;
    bit          skip;
    int unsigned ticks_left;
    int          dir_x;
    int          dir_y;

    escape_cmd_t cmd_due[$];
    int unsigned bad_cmds;

    function new();
      grid_w     = GRID_WIDTH_RST;
      grid_h     = GRID_HEIGHT_RST;
      bot_col    = ROBOT_COL_RST;
      bot_row    = ROBOT_ROW_RST;
      radius     = RADIUS_RST;
      cost_thr   = COST_THR_RST;
      speed      = SPEED_RST;
      ticks_cfg  = TICKS_RST;
      col_pos    = 0;
      row_pos    = 0;
      sum_x      = 0;
      sum_y      = 0;
      hit        = 1'b0;
      escaping   = 1'b0;
      skip       = 1'b0;
      ticks_left = 0;
      dir_x      = 0;
      dir_y      = 0;
      bad_cmds   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_GRID_WIDTH:     grid_w    = val[DIM_W-1:0];
        CFG_GRID_HEIGHT:    grid_h    = val[DIM_W-1:0];
        CFG_ROBOT_COL:      bot_col   = val[COORD_W-1:0];
        CFG_ROBOT_ROW:      bot_row   = val[COORD_W-1:0];
        CFG_RADIUS_CELLS:   radius    = val[RADIUS_W-1:0];
        CFG_COST_THRESHOLD: cost_thr  = val[COST_W-1:0];
        CFG_ESCAPE_SPEED:   speed     = val[SPEED_W-1:0];
        CFG_ESCAPE_TICKS:   ticks_cfg = val[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned dim_clamp(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > GRID_DIM_MAX) return GRID_DIM_MAX;
      return v;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v   -= res + probe;
          res  = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    function int scale_speed(int d);
      longint unsigned a;
      longint unsigned p;
      a = (d < 0) ? longint'(-d) : longint'(d);
      p = (a * speed + 64'd16384) >> 15;
      return (d < 0) ? -int'(p) : int'(p);
    endfunction

    // Unit away direction in Q1.15; fall back when the sum cancels out
    function void away_heading(output int hx, output int hy);
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned m;
      longint unsigned qx;
      longint unsigned qy;
      ax = (sum_x < 0) ? -sum_x : sum_x;
      ay = (sum_y < 0) ? -sum_y : sum_y;
      if (ax == 0 && ay == 0) begin
        if (dir_x != 0 || dir_y != 0) begin
          hx = dir_x;
          hy = dir_y;
        end else begin
          hx = 0;
          hy = -int'(DIR_BACK_MAG);
        end
        return;
      end
      while ((ax | ay) < (64'd1 << 15)) begin
        ax <<= 1;
        ay <<= 1;
      end
      while ((ax | ay) >= (64'd1 << 16)) begin
        ax >>= 1;
        ay >>= 1;
      end
      m  = root_floor((ax * ax + ay * ay) << 30);
      qx = ((ax << 30) + m / 2) / m;
      qy = ((ay << 30) + m / 2) / m;
      if (qx > 32767) qx = 32767;
      if (qy > 32767) qy = 32767;
      hx = (sum_x < 0) ? -int'(qx) : int'(qx);
      hy = (sum_y < 0) ? -int'(qy) : int'(qy);
      dir_x = hx;
      dir_y = hy;
    endfunction

    // Advance the scan by one accepted word and queue any command it causes
    function void take_word(logic mode, logic signed [COST_W-1:0] cost);
      int unsigned w;
      int unsigned h;
      int          r;
      int          ox;
      int          oy;
      int          hx;
      int          hy;
      bit          row_end;
      bit          frame_end;
      if (mode == MODE_TICK) begin
        if (!escaping) return;
        if (ticks_left <= 1) begin
          ticks_left = 0;
          escaping   = 1'b0;
          cmd_due.push_back('{CMD_STOP, '0, '0});
        end else begin
          ticks_left--;
        end
        return;
      end
      w = dim_clamp(grid_w);
      h = dim_clamp(grid_h);
      r = (radius > RADIUS_MAX) ? RADIUS_MAX : int'(radius);
      if (col_pos == 0 && row_pos == 0) begin
        skip  = escaping;
        sum_x = 0;
        sum_y = 0;
        hit   = 1'b0;
      end
      if (!skip) begin
        ox = int'(bot_col) - int'(col_pos);
        oy = int'(bot_row) - int'(row_pos);
        if (ox * ox + oy * oy <= r * r && cost >= cost_thr) begin
          sum_x += ox;
          sum_y += oy;
          hit    = 1'b1;
        end
      end
      row_end   = (col_pos >= w - 1);
      frame_end = row_end && (row_pos >= h - 1);
      if (frame_end) begin
        if (!skip && hit) begin
          away_heading(hx, hy);
          cmd_due.push_back('{CMD_START, VEL_W'(scale_speed(hy)), VEL_W'(-scale_speed(hx))});
          escaping   = 1'b1;
          ticks_left = ticks_cfg;
        end
        col_pos = 0;
        row_pos = 0;
      end else if (row_end) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    // Compare one emitted command with the oldest one due
    function void match_cmd(logic kind, logic signed [VEL_W-1:0] fwd,
                            logic signed [VEL_W-1:0] lft);
      escape_cmd_t want;
      if (cmd_due.size() == 0) begin
        $display("%0t: command with none due: kind %0d fwd %0d left %0d",
                 $time, kind, fwd, lft);
        bad_cmds++;
        return;
      end
      want = cmd_due.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: command_kind expected %0d got %0d", $time, want.kind, kind);
        bad_cmds++;
      end
      if (fwd !== want.fwd_v) begin
        $display("%0t: vel_forward expected %0d got %0d", $time, want.fwd_v, fwd);
        bad_cmds++;
      end
      if (lft !== want.left_v) begin
        $display("%0t: vel_left expected %0d got %0d", $time, want.left_v, lft);
        bad_cmds++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  cfg_idx_e                 cfg_index_i = CFG_GRID_WIDTH;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     mode_i = MODE_CELL;
  logic signed [COST_W-1:0] cell_cost_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     command_kind_o;
  logic signed [VEL_W-1:0]  vel_forward_o;
  logic signed [VEL_W-1:0]  vel_left_o;

  escape_cmd_model  sb;
  logic [CFG_W-1:0] reg_plan [8];
  int unsigned      send_idle_pct = 36;
  int unsigned      recv_idle_pct = 52;

  footprint_collision_escape u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .cell_cost_i    (cell_cost_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .command_kind_o (command_kind_o),
    .vel_forward_o  (vel_forward_o),
    .vel_left_o     (vel_left_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stall the command side at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every command word taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.match_cmd(command_kind_o, vel_forward_o, vel_left_o);
    end
  end

  // Write all registers from reg_plan, one per cycle
  task automatic program_regs();
    cfg_idx_e idx;
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= reg_plan[idx];
      sb.set_reg(idx, reg_plan[idx]);
      @(negedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  // Present one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(logic mode, logic signed [COST_W-1:0] cost);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    cell_cost_i <= cost;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_word(mode, cost);
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every command due
  task automatic hold_for_cmds();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.cmd_due.size() != 0);
  endtask

  task automatic settle();
    hold_for_cmds();
    repeat (100) @(negedge clk_i);
  endtask

  // Cells with costs at or just below the threshold, at the extremes or random; ticks mostly while escaping
  task automatic random_word();
    logic signed [COST_W-1:0] c;
    int unsigned              tick_pct;
    tick_pct = sb.escaping ? 75 : 5;
    if ($urandom_range(99) < tick_pct) begin
      send_word(MODE_TICK, COST_W'($urandom_range(255)));
    end else begin
      case ($urandom_range(5))
        0:       c = sb.cost_thr;
        1:       c = sb.cost_thr - 8'sd1;
        2:       c = 8'h7F;
        3:       c = 8'h80;
        default: c = COST_W'($urandom_range(255));
      endcase
      send_word(MODE_CELL, c);
    end
  endtask

  task automatic plan_small_regs();
    int unsigned w;
    int unsigned h;
    case ($urandom_range(9))
      0:       w = 0;
      1:       w = 1;
      default: w = $urandom_range(2, 8);
    endcase
    case ($urandom_range(9))
      0:       h = 0;
      1:       h = 1;
      default: h = $urandom_range(2, 8);
    endcase
    reg_plan[CFG_GRID_WIDTH]  = CFG_W'(w);
    reg_plan[CFG_GRID_HEIGHT] = CFG_W'(h);
    reg_plan[CFG_ROBOT_COL]   = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1023))
                                                         : CFG_W'($urandom_range(w + 2));
    reg_plan[CFG_ROBOT_ROW]   = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1023))
                                                         : CFG_W'($urandom_range(h + 2));
    reg_plan[CFG_RADIUS_CELLS]   = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(63))
                                                            : CFG_W'($urandom_range(4));
    reg_plan[CFG_COST_THRESHOLD] = CFG_W'($urandom_range(65535));
    reg_plan[CFG_ESCAPE_SPEED]   = CFG_W'($urandom_range(4095));
    reg_plan[CFG_ESCAPE_TICKS]   = CFG_W'($urandom_range(10));
  endtask

  initial begin
    #15ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int unsigned n_words;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 3x3 grid, robot in the middle, one-cell radius, zero escape duration
    reg_plan[CFG_GRID_WIDTH]     = 16'd3;
    reg_plan[CFG_GRID_HEIGHT]    = 16'd3;
    reg_plan[CFG_ROBOT_COL]      = 16'd1;
    reg_plan[CFG_ROBOT_ROW]      = 16'd1;
    reg_plan[CFG_RADIUS_CELLS]   = 16'd1;
    reg_plan[CFG_COST_THRESHOLD] = 16'd0;
    reg_plan[CFG_ESCAPE_SPEED]   = 16'd4095;
    reg_plan[CFG_ESCAPE_TICKS]   = 16'd0;
    program_regs();

    // Tick while idle is dropped
    send_word(MODE_TICK, 8'h55);
    // Left and right obstacles cancel: back straight out at full speed
    send_word(MODE_CELL, 8'h7F);
    send_word(MODE_CELL, -8'sd1);
    send_word(MODE_CELL, 8'h7F);
    send_word(MODE_CELL, 8'sd0);
    send_word(MODE_CELL, 8'h80);
    send_word(MODE_CELL, 8'h7F);
    send_word(MODE_CELL, 8'h80);
    send_word(MODE_CELL, -8'sd1);
    send_word(MODE_CELL, 8'sd100);
    // First tick of a zero-length escape stops
    send_word(MODE_TICK, 8'h2A);
    // Obstacle above plus one on the robot cell
    send_word(MODE_CELL, 8'h7F);
    send_word(MODE_CELL, 8'h7F);
    send_word(MODE_CELL, 8'h80);
    send_word(MODE_CELL, -8'sd1);
    send_word(MODE_CELL, 8'sd0);
    send_word(MODE_CELL, -8'sd1);
    send_word(MODE_CELL, 8'h80);
    send_word(MODE_CELL, -8'sd1);
    send_word(MODE_CELL, 8'h80);
    send_word(MODE_TICK, 8'h00);
    settle();

    // Random phases; frame position and escape carry over between them
    for (int p = 0; p < 15; p++) begin
      if (p < 5) begin
        send_idle_pct = 36;
        recv_idle_pct = 52;
      end else if (p < 10) begin
        send_idle_pct = 52;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      plan_small_regs();
      n_words = $urandom_range(38, 52);
      case (p)
        2: begin
          reg_plan[CFG_COST_THRESHOLD] = 16'hFF80;
          reg_plan[CFG_ESCAPE_SPEED]   = 16'd0;
        end
        4: begin
          // Clamped full-width row, robot at the last column
          reg_plan[CFG_GRID_WIDTH]   = 16'd2047;
          reg_plan[CFG_GRID_HEIGHT]  = 16'd0;
          reg_plan[CFG_ROBOT_COL]    = 16'd1023;
          reg_plan[CFG_ROBOT_ROW]    = 16'd0;
          reg_plan[CFG_RADIUS_CELLS] = 16'd63;
        end
        7: begin
          // Clamped full-height column, robot at the last row
          reg_plan[CFG_GRID_WIDTH]   = 16'd0;
          reg_plan[CFG_GRID_HEIGHT]  = CFG_W'($urandom_range(1025, 2047));
          reg_plan[CFG_ROBOT_COL]    = 16'd0;
          reg_plan[CFG_ROBOT_ROW]    = 16'd1023;
          reg_plan[CFG_RADIUS_CELLS] = 16'd63;
        end
        9: begin
          reg_plan[CFG_COST_THRESHOLD] = 16'd127;
          reg_plan[CFG_ESCAPE_SPEED]   = 16'd4095;
        end
        default: ;
      endcase
      program_regs();
      for (int k = 0; k < n_words; k++) begin
        if ($urandom_range(199) == 0) hold_for_cmds();
        random_word();
      end
      settle();
    end

    // Long escape: finish any open one, then run a full tick count
    while (sb.escaping) send_word(MODE_TICK, COST_W'($urandom_range(255)));
    settle();
    reg_plan[CFG_GRID_WIDTH]     = 16'd1;
    reg_plan[CFG_GRID_HEIGHT]    = 16'd1;
    reg_plan[CFG_ROBOT_COL]      = 16'd0;
    reg_plan[CFG_ROBOT_ROW]      = 16'd0;
    reg_plan[CFG_RADIUS_CELLS]   = 16'd0;
    reg_plan[CFG_COST_THRESHOLD] = 16'hFF80;
    reg_plan[CFG_ESCAPE_SPEED]   = CFG_W'($urandom_range(4095));
    reg_plan[CFG_ESCAPE_TICKS]   = 16'd60;
    program_regs();
    while (!sb.escaping) send_word(MODE_CELL, COST_W'($urandom_range(255)));
    while (sb.escaping) send_word(MODE_TICK, COST_W'($urandom_range(255)));
    settle();

    if (sb.bad_cmds == 0 && sb.cmd_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
